### hdl/fsmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmm_pkg
// Shared types and constants of the frame stack mean and minimum block.
// ----------------------------------------------------------------------------
package fsmm_pkg;

  // Field widths of the stream payloads
  localparam int PIXEL_W   = 8;
  localparam int MEAN_W    = 8;
  localparam int PIX_IDX_W = 18;

  // Configuration register widths
  localparam int FRAME_COUNT_W = 12;
  localparam int PIXEL_COUNT_W = 19;

  // APB port widths
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Configuration register indexes (byte address is 4 times the index)
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_PIXEL_COUNT = 1'b1;

  // Input request payload
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
  } fsmm_pixel_t;

  // Output request payload
  typedef struct packed {
    logic [MEAN_W-1:0]    mean_value;
    logic [PIXEL_W-1:0]   min_value;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic                 last_pixel;
  } fsmm_result_t;

  // Classification of one pixel, made by the front end
  typedef struct packed {
    logic first_frame;
    logic last_frame;
    logic last_pixel;
  } fsmm_tag_t;

endpackage
`default_nettype wire

### hdl/fsmm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmm_if
// Valid/ready stream interfaces for pixels in and results out.
// ----------------------------------------------------------------------------
interface fsmm_pixel_if;
  import fsmm_pkg::*;

  logic        valid;
  logic        ready;
  fsmm_pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsmm_result_if;
  import fsmm_pkg::*;

  logic         valid;
  logic         ready;
  fsmm_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/fsmm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmm_front
// Accepts pixels, tracks raster position and frame number, and tags each
// pixel as first frame, last frame and last pixel for the back end.
// ----------------------------------------------------------------------------
module fsmm_front #(
  parameter int PIX_AW = 18,
  parameter int FC_W   = 11,
  parameter int FR_W   = 12,
  parameter int PC_W   = 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic [FR_W-1:0]               eff_frames,
  input  logic [PC_W-1:0]               eff_pixels,
  fsmm_pixel_if.sink                    pix,
  output logic                          q_valid,
  input  logic                          q_ready,
  output fsmm_pkg::fsmm_tag_t           q_tag,
  output logic [fsmm_pkg::PIXEL_W-1:0]  q_px,
  output logic [PIX_AW-1:0]             q_idx
);
  import fsmm_pkg::*;

  logic [PIX_AW-1:0] pixel_cnt;
  logic [FC_W-1:0]   frame_cnt;
  logic              accept;
  logic              last_frame;
  logic              last_pix;

  // Classify the current position
  assign last_frame = (32'(frame_cnt) + 32'd1) >= 32'(eff_frames);
  assign last_pix   = (32'(pixel_cnt) + 32'd1) >= 32'(eff_pixels);

  assign accept    = pix.valid && q_ready;
  assign pix.ready = q_ready;

  // Hand the tagged request to the queue
  assign q_valid           = pix.valid;
  assign q_px              = pix.data.pixel;
  assign q_idx             = pixel_cnt;
  assign q_tag.first_frame = (frame_cnt == '0);
  assign q_tag.last_frame  = last_frame;
  assign q_tag.last_pixel  = last_pix;

  // Advance raster and frame counters, wrap at the end of a set
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pixel_cnt <= '0;
      frame_cnt <= '0;
    end else if (accept) begin
      if (last_pix) begin
        pixel_cnt <= '0;
        if (last_frame) begin
          frame_cnt <= '0;
        end else begin
          frame_cnt <= frame_cnt + 1'b1;
        end
      end else begin
        pixel_cnt <= pixel_cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/fsmm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmm_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fsmm_queue #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/fsmm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmm_div
// Restoring divider, one quotient bit per cycle, for the 8-bit mean.
// ----------------------------------------------------------------------------
module fsmm_div #(
  parameter int SUM_W = 19,
  parameter int FR_W  = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [FR_W-1:0]              divisor,
  output logic                         done,
  output logic [fsmm_pkg::MEAN_W-1:0]  quotient
);
  import fsmm_pkg::*;

  localparam int DW = (SUM_W > FR_W + MEAN_W - 1) ? SUM_W : FR_W + MEAN_W - 1;
  localparam int SW = $clog2(MEAN_W);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [SW-1:0] step;
  logic          busy;
  logic          fits;

  assign fits = (rem >= dsh);

  // Shift and subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DW'(dividend);
      dsh      <= DW'(divisor) << (MEAN_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[MEAN_W-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SW'(MEAN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/fsmm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmm_back
// Read-modify-write of the per-pixel sum and minimum stores, mean division
// and result register for the last frame of a set.
// ----------------------------------------------------------------------------
module fsmm_back #(
  parameter int MAX_PIXELS = 262144,
  parameter int PIX_AW     = 18,
  parameter int FR_W       = 12,
  parameter int SUM_W      = 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [FR_W-1:0]               eff_frames,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  fsmm_pkg::fsmm_tag_t           q_tag,
  input  logic [fsmm_pkg::PIXEL_W-1:0]  q_px,
  input  logic [PIX_AW-1:0]             q_idx,
  fsmm_result_if.source                 res
);
  import fsmm_pkg::*;

  localparam int WORD_W = SUM_W + PIXEL_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_OUTPUT = 4'b1000
  } back_state_t;

  back_state_t       state;
  back_state_t       state_next;

  logic [WORD_W-1:0] store [MAX_PIXELS];
  logic [WORD_W-1:0] rd_word;
  logic [SUM_W-1:0]  rd_sum;
  logic [PIXEL_W-1:0] rd_min;

  fsmm_tag_t         job_tag;
  logic [PIXEL_W-1:0] job_px;
  logic [PIX_AW-1:0] job_idx;

  logic [SUM_W-1:0]  new_sum;
  logic [PIXEL_W-1:0] new_min;
  logic [PIXEL_W-1:0] out_min;
  logic [PIX_IDX_W-1:0] out_idx;
  logic              out_last;

  logic              pop;
  logic              div_start;
  logic              div_done;
  logic [MEAN_W-1:0] div_quo;

  assign q_ready = (state == ST_IDLE);
  assign pop     = q_valid && q_ready;

  assign rd_sum = rd_word[WORD_W-1:PIXEL_W];
  assign rd_min = rd_word[PIXEL_W-1:0];

  // Merge the new pixel into the stored entry
  always_comb begin
    if (job_tag.first_frame) begin
      new_sum = SUM_W'(job_px);
      new_min = job_px;
    end else begin
      new_sum = rd_sum + SUM_W'(job_px);
      new_min = (job_px < rd_min) ? job_px : rd_min;
    end
  end

  // Store: read on pop, write back in the update cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_word <= store[q_idx];
    end
    if (state == ST_UPDATE) begin
      store[job_idx] <= {new_sum, new_min};
    end
  end

  // Hold the request under work
  always_ff @(posedge clk) begin
    if (pop) begin
      job_tag <= q_tag;
      job_px  <= q_px;
      job_idx <= q_idx;
    end
  end

  // Capture result fields at update
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      out_min  <= new_min;
      out_idx  <= PIX_IDX_W'(job_idx);
      out_last <= job_tag.last_pixel;
    end
  end

  assign div_start = (state == ST_UPDATE) && job_tag.last_frame;

  fsmm_div #(
    .SUM_W (SUM_W),
    .FR_W  (FR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (eff_frames),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequence one request at a time
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = job_tag.last_frame ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive the result request
  assign res.valid            = (state == ST_OUTPUT);
  assign res.data.mean_value  = div_quo;
  assign res.data.min_value   = out_min;
  assign res.data.pixel_index = out_idx;
  assign res.data.last_pixel  = out_last;

`ifndef SYNTHESIS
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_plain_update_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && !job_tag.last_frame) |=> state == ST_IDLE)
    else $error("non-final frame update did not return to idle");

  a_min_below_mean: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.data.min_value <= res.data.mean_value)
    else $error("minimum above truncated mean");

  a_final_divides: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && job_tag.last_frame) |=> state == ST_DIVIDE)
    else $error("last frame update skipped the divider");
`endif

endmodule
`default_nettype wire

### hdl/frame_stack_mean_min.sv
`default_nettype none
// A pixel of the last frame passes the queue, the update state, the divider and the
// output state before its result is offered. Pixels are taken one at a time, set by the
// single store port (read, then write) and, in the last frame, the bit-serial divider.
// A two-entry queue accepts up to two pixels while a result waits to be taken.
// Reset: counters clear, frame_count = 1, pixel_count = 262144; the stores are not
// cleared, since the first frame of every set writes each entry before it is read.
// ----------------------------------------------------------------------------
// frame_stack_mean_min
// Temporal mean and minimum background over a set of frames, with APB setup.
// ----------------------------------------------------------------------------
module frame_stack_mean_min #(
  parameter int MAX_PIXELS = 262144,
  parameter int MAX_FRAMES = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fsmm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fsmm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fsmm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  fsmm_pixel_if.sink                          pix,
  fsmm_result_if.source                       res
);
  import fsmm_pkg::*;

  localparam int PIX_AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int FC_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FR_W   = $clog2(MAX_FRAMES + 1);
  localparam int PC_W   = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W  = PIXEL_W + $clog2(MAX_FRAMES);
  localparam int JOB_W  = $bits(fsmm_tag_t) + PIXEL_W + PIX_AW;

  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [PIXEL_COUNT_W-1:0] pixel_count;
  logic [FR_W-1:0]          eff_frames;
  logic [PC_W-1:0]          eff_pixels;
  logic                     cfg_write;

  logic                     f_valid;
  logic                     f_ready;
  fsmm_tag_t                f_tag;
  logic [PIXEL_W-1:0]       f_px;
  logic [PIX_AW-1:0]        f_idx;

  logic                     b_valid;
  logic                     b_ready;
  logic [JOB_W-1:0]         b_job;
  fsmm_tag_t                b_tag;
  logic [PIXEL_W-1:0]       b_px;
  logic [PIX_AW-1:0]        b_idx;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_W'(1);
      pixel_count <= PIXEL_COUNT_W'(262144);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_FRAME_COUNT: frame_count <= pwdata[FRAME_COUNT_W-1:0];
        REG_PIXEL_COUNT: pixel_count <= pwdata[PIXEL_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count);
      REG_PIXEL_COUNT: prdata = APB_DATA_W'(pixel_count);
      default:         prdata = '0;
    endcase
  end

  // Clamp the set geometry to the supported range
  always_comb begin
    if (frame_count == '0) begin
      eff_frames = FR_W'(1);
    end else if (32'(frame_count) > 32'(MAX_FRAMES)) begin
      eff_frames = FR_W'(MAX_FRAMES);
    end else begin
      eff_frames = FR_W'(frame_count);
    end
    if (pixel_count == '0) begin
      eff_pixels = PC_W'(1);
    end else if (32'(pixel_count) > 32'(MAX_PIXELS)) begin
      eff_pixels = PC_W'(MAX_PIXELS);
    end else begin
      eff_pixels = PC_W'(pixel_count);
    end
  end

  fsmm_front #(
    .PIX_AW (PIX_AW),
    .FC_W   (FC_W),
    .FR_W   (FR_W),
    .PC_W   (PC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_write),
    .eff_frames (eff_frames),
    .eff_pixels (eff_pixels),
    .pix        (pix),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_tag      (f_tag),
    .q_px       (f_px),
    .q_idx      (f_idx)
  );

  fsmm_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_tag, f_px, f_idx}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_job)
  );

  assign {b_tag, b_px, b_idx} = b_job;

  fsmm_back #(
    .MAX_PIXELS (MAX_PIXELS),
    .PIX_AW     (PIX_AW),
    .FR_W       (FR_W),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .eff_frames (eff_frames),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_tag      (b_tag),
    .q_px       (b_px),
    .q_idx      (b_idx),
    .res        (res)
  );

endmodule
`default_nettype wire
